@@ hdl/alsd_pkg.sv @@
// Shared types and constants for the addressable LED strip driver.
`default_nettype none
package alsd_pkg;

    localparam int LED_COUNT = 8;
    localparam int PIX_AW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int PIXEL_W   = 24;
    localparam int TICK_W    = 16;
    localparam int BIT_CNT_W = 5;
    localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(PIXEL_W - 1);
    localparam logic [PIX_AW-1:0]    PIX_LAST   = PIX_AW'(LED_COUNT - 1);
    localparam logic [8:0]           PIX_LIMIT  = 9'(LED_COUNT);

    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 16'd80;
    localparam logic [TICK_W-1:0] ONE_LOW_RST   = 16'd45;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 16'd40;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 16'd85;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FILL  = 2'd2,
        OP_SHOW  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_ONE_HIGH  = 2'd0,
        CFG_ONE_LOW   = 2'd1,
        CFG_ZERO_HIGH = 2'd2,
        CFG_ZERO_LOW  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_op        operation;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_done;
    } t_out_item;

    // Request from the frame controller to the pixel store.
    typedef struct packed {
        logic                wr_en;
        logic                fill_en;
        logic                rd_en;
        logic [PIX_AW-1:0]   wr_addr;
        logic [PIX_AW-1:0]   rd_addr;
        logic [PIXEL_W-1:0]  wdata;
    } t_store_req;

endpackage
`default_nettype wire

@@ hdl/alsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module alsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/alsd_pixel_store.sv @@
// Pixel store: RAM plus per-entry valid bits and a fill word, so fill and reset reach every entry without RAM writes.
`default_nettype none
module alsd_pixel_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire alsd_pkg::t_store_req          i_req,
    output logic      [alsd_pkg::PIXEL_W-1:0]  o_rdata
);

    logic [alsd_pkg::LED_COUNT-1:0] r_valid;
    logic [alsd_pkg::PIXEL_W-1:0]   r_fill_word;
    logic                           r_rd_valid;
    logic [alsd_pkg::PIXEL_W-1:0]   ram_rdata;

    alsd_ram #(
        .WIDTH (alsd_pkg::PIXEL_W),
        .DEPTH (alsd_pkg::LED_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_waddr (i_req.wr_addr),
        .i_wdata (i_req.wdata),
        .i_re    (i_req.rd_en),
        .i_raddr (i_req.rd_addr),
        .o_rdata (ram_rdata)
    );

    // An entry not written since the last fill reads as the fill word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fill_word <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_req.fill_en) begin
                r_valid     <= '0;
                r_fill_word <= i_req.wdata;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? ram_rdata : r_fill_word;

endmodule
`default_nettype wire

@@ hdl/addressable_led_strip_driver_top.sv @@
// Top level: operation decode, bit timing and frame sequencing over the pixel store.
// Every transaction gives one result, registered in the cycle after it is accepted.
// A frame start and a tick that moves on to the next pixel also pass through a load state
// that takes the pixel from the registered read of the pixel RAM; no transaction is taken there.
// A new transaction is taken while the previous result waits only if that result leaves now.
// Synchronous active-low reset clears control state; the store reads zero at once.
`default_nettype none
module addressable_led_strip_driver_top (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire alsd_pkg::t_in_item     i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output alsd_pkg::t_out_item         o_out_data,
    input  wire logic                   i_cfg_we,
    input  wire alsd_pkg::t_cfg_idx     i_cfg_index,
    input  wire logic [15:0]            i_cfg_wdata
);

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_busy, n_busy;
    logic                            r_low, n_low;
    logic [alsd_pkg::TICK_W-1:0]     r_phase, n_phase;
    logic [alsd_pkg::BIT_CNT_W-1:0]  r_bit, n_bit;
    logic [alsd_pkg::PIX_AW-1:0]     r_pix, n_pix;
    logic [alsd_pkg::PIXEL_W-1:0]    r_shift, n_shift;
    logic [alsd_pkg::TICK_W-1:0]     r_one_high, r_one_low, r_zero_high, r_zero_low;
    logic                            r_out_valid, n_out_valid;
    alsd_pkg::t_out_item             r_out, n_out;

    alsd_pkg::t_store_req            store_req;
    logic [alsd_pkg::PIXEL_W-1:0]    store_rdata;
    logic                            accept;
    logic                            in_range;
    logic [alsd_pkg::TICK_W-1:0]     dur_sel, duration, phase_inc;

    alsd_pixel_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rdata (store_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_range    = {1'b0, i_in_data.pixel_index} < alsd_pkg::PIX_LIMIT;

    // Duration of the current part; a zero setting behaves as one tick.
    always_comb begin
        if (r_shift[alsd_pkg::PIXEL_W-1]) begin
            dur_sel = r_low ? r_one_low : r_one_high;
        end else begin
            dur_sel = r_low ? r_zero_low : r_zero_high;
        end
        duration  = (dur_sel == '0) ? alsd_pkg::TICK_W'(1) : dur_sel;
        phase_inc = r_phase + alsd_pkg::TICK_W'(1);
    end

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_low       = r_low;
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_pix       = r_pix;
        n_shift     = r_shift;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        store_req   = '0;
        store_req.wr_addr = i_in_data.pixel_index[alsd_pkg::PIX_AW-1:0];
        store_req.wdata   = {i_in_data.green, i_in_data.red, i_in_data.blue};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                n_shift = store_rdata;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    unique case (i_in_data.operation)
                        alsd_pkg::OP_TICK: begin
                            if (r_busy) begin
                                if (phase_inc >= duration) begin
                                    n_phase = '0;
                                    if (!r_low) begin
                                        n_low = 1'b1;
                                    end else begin
                                        n_low   = 1'b0;
                                        n_shift = {r_shift[alsd_pkg::PIXEL_W-2:0], 1'b0};
                                        if (r_bit == alsd_pkg::BIT_LAST) begin
                                            n_bit = '0;
                                            if (r_pix == alsd_pkg::PIX_LAST) begin
                                                n_pix  = '0;
                                                n_busy = 1'b0;
                                                n_out.frame_done = 1'b1;
                                            end else begin
                                                n_pix  = r_pix + alsd_pkg::PIX_AW'(1);
                                                store_req.rd_en   = 1'b1;
                                                store_req.rd_addr = n_pix;
                                                n_state = S_LOAD;
                                            end
                                        end else begin
                                            n_bit = r_bit + alsd_pkg::BIT_CNT_W'(1);
                                        end
                                    end
                                end else begin
                                    n_phase = phase_inc;
                                end
                            end
                        end
                        alsd_pkg::OP_WRITE: begin
                            store_req.wr_en = !r_busy && in_range;
                        end
                        alsd_pkg::OP_FILL: begin
                            store_req.fill_en = !r_busy;
                        end
                        alsd_pkg::OP_SHOW: begin
                            if (!r_busy) begin
                                n_busy  = 1'b1;
                                n_low   = 1'b0;
                                n_phase = '0;
                                n_bit   = '0;
                                n_pix   = '0;
                                store_req.rd_en   = 1'b1;
                                store_req.rd_addr = '0;
                                n_state = S_LOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // A tick reports the level it spent; other operations report the new state.
                    if (i_in_data.operation == alsd_pkg::OP_TICK) begin
                        n_out.busy_res  = r_busy;
                        n_out.pin_level = r_busy && !r_low;
                    end else begin
                        n_out.busy_res  = n_busy;
                        n_out.pin_level = n_busy && !n_low;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_low       <= 1'b0;
            r_phase     <= '0;
            r_bit       <= '0;
            r_pix       <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
            r_one_high  <= alsd_pkg::ONE_HIGH_RST;
            r_one_low   <= alsd_pkg::ONE_LOW_RST;
            r_zero_high <= alsd_pkg::ZERO_HIGH_RST;
            r_zero_low  <= alsd_pkg::ZERO_LOW_RST;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_low       <= n_low;
            r_phase     <= n_phase;
            r_bit       <= n_bit;
            r_pix       <= n_pix;
            r_shift     <= n_shift;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    alsd_pkg::CFG_ONE_HIGH:  r_one_high  <= i_cfg_wdata;
                    alsd_pkg::CFG_ONE_LOW:   r_one_low   <= i_cfg_wdata;
                    alsd_pkg::CFG_ZERO_HIGH: r_zero_high <= i_cfg_wdata;
                    alsd_pkg::CFG_ZERO_LOW:  r_zero_low  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // A pixel load only happens inside a frame.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> r_busy)
        else $error("pixel load outside a frame");

    // A new transaction may only be taken while a pending result leaves.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid) |-> i_out_ready)
        else $error("result overwritten");

    // Frame end is reported only on a tick spent inside a frame.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_done) |-> o_out_data.busy_res)
        else $error("frame end while idle");

    // The pin is never high outside a frame.
    a_pin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.pin_level) |-> o_out_data.busy_res)
        else $error("pin high while idle");

endmodule
`default_nettype wire
